// ===== hw/rtl/pole_zero_iir_filter_top_assert.svh =====
// Assertion macros for the pole/zero IIR filter checker.
// Clocked on clk; the first form is disabled during reset, the second is not.
`ifndef POLE_ZERO_IIR_FILTER_TOP_ASSERT_SVH
`define POLE_ZERO_IIR_FILTER_TOP_ASSERT_SVH

// Property checked outside reset.
`define PZF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define PZF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pzf_pkg.sv =====
// Shared types, constants and the round/saturate function of the IIR filter.
// No dependencies.
`default_nettype none

package pzf_pkg;

  localparam int ORDER      = 3;
  localparam int NUM_REGS   = 7;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int COEF_W     = 18;
  localparam int SAMPLE_W   = 16;
  localparam int FRAC_SHIFT = 14;
  localparam int PROD_W     = COEF_W + SAMPLE_W;
  // seven products fit in three extra bits; one more for headroom
  localparam int ACC_W      = PROD_W + 4;
  localparam int QUOT_W     = ACC_W - FRAC_SHIFT;
  localparam int ROUND_HALF = 2 ** (FRAC_SHIFT - 1);
  localparam int COEF_ONE   = 2 ** FRAC_SHIFT;
  localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));

  // register indexes
  localparam int REG_ZERO_0 = 0;
  localparam int REG_POLE_1 = 4;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    coef_t [ORDER:0] zero;
    coef_t [ORDER:1] pole;
  } coef_bank_t;

  // reset bank: unit gain on the current input, everything else zero
  localparam coef_bank_t COEF_RESET = '{
    zero: {{(ORDER*COEF_W){1'b0}}, COEF_W'(COEF_ONE)},
    pole: '0
  };

  typedef struct packed {
    sample_t sample;
    logic    sat;
  } result_t;

  function automatic result_t round_sat(acc_t acc);
    acc_t                     biased;
    logic signed [QUOT_W-1:0] quot;
    result_t                  res;
    biased = acc + acc_t'(ROUND_HALF);
    quot   = biased[ACC_W-1:FRAC_SHIFT];
    priority if (quot > QUOT_W'(SAMPLE_MAX)) begin
      res.sample = sample_t'(SAMPLE_MAX);
      res.sat    = 1'b1;
    end else if (quot < QUOT_W'(SAMPLE_MIN)) begin
      res.sample = sample_t'(SAMPLE_MIN);
      res.sat    = 1'b1;
    end else begin
      res.sample = quot[SAMPLE_W-1:0];
      res.sat    = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pole_zero_iir_filter_top.sv =====
// Direct form I IIR filter, order 3, Q1.15 samples, Q4.14 coefficients.
// Holds the coefficient bank, the chain of tap cells and the output register.
// Depends on pzf_pkg, pzf_coef_bank and pzf_tap_cell.
//
// Usage:
//   Input channel in_valid/in_ready/in_sample carries one sample per item.
//   Output channel out_valid/out_ready/out_sample/out_saturated returns one
//   filtered sample per item; out_saturated flags a clipped result.
//   Coefficients are written through cfg_wr_en/cfg_index/cfg_data, index 0..3
//   for the zero coefficients and 4..6 for pole coefficients 1..3; other
//   indexes are ignored. Write only while the filter is idle.
//   Latency: the result of an item appears in the cycle after it is accepted.
//   Throughput: one item per cycle while the receiver takes each result. The
//   whole multiply-accumulate over the histories, rounding and saturation are
//   combinational, since the newest output feeds the next sum.
//   Reset (rst_n low, synchronous) clears both histories, sets zero
//   coefficient 0 to 1.0 and all others to 0, and empties the output register.
//   When the receiver stalls, the result holds and in_ready stays low until it
//   is taken; with out_ready high a new item is taken in the same cycle.
`default_nettype none

module pole_zero_iir_filter_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic signed [15:0]             in_sample,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic signed [15:0]             out_sample,
  output      logic                           out_saturated,
  input  wire logic                           cfg_wr_en,
  input  wire logic [pzf_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [pzf_pkg::COEF_W-1:0]     cfg_data
);

  pzf_pkg::coef_bank_t coef;
  pzf_pkg::prod_t      lead_prod;
  pzf_pkg::acc_t       sum_link [0:pzf_pkg::ORDER];
  pzf_pkg::sample_t    x_link   [0:pzf_pkg::ORDER-1];
  pzf_pkg::sample_t    y_link   [0:pzf_pkg::ORDER-1];
  pzf_pkg::result_t    res;
  logic                accept;
  logic                out_valid_r, out_valid_nxt;
  pzf_pkg::sample_t    out_sample_r;
  logic                out_sat_r;

  pzf_coef_bank u_coef_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign lead_prod   = pzf_pkg::prod_t'(coef.zero[0]) * pzf_pkg::prod_t'(in_sample);
  assign sum_link[0] = pzf_pkg::acc_t'(lead_prod);
  assign x_link[0]   = in_sample;
  assign y_link[0]   = res.sample;

  for (genvar k = 1; k <= pzf_pkg::ORDER; k++) begin : g_tap
    if (k < pzf_pkg::ORDER) begin : g_mid
      pzf_tap_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (accept),
        .x_in      (x_link[k-1]),
        .y_in      (y_link[k-1]),
        .zero_coef (coef.zero[k]),
        .pole_coef (coef.pole[k]),
        .sum_in    (sum_link[k-1]),
        .x_out     (x_link[k]),
        .y_out     (y_link[k]),
        .sum_out   (sum_link[k])
      );
    end else begin : g_last
      pzf_tap_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (accept),
        .x_in      (x_link[k-1]),
        .y_in      (y_link[k-1]),
        .zero_coef (coef.zero[k]),
        .pole_coef (coef.pole[k]),
        .sum_in    (sum_link[k-1]),
        .x_out     (),
        .y_out     (),
        .sum_out   (sum_link[k])
      );
    end
  end

  assign res = pzf_pkg::round_sat(sum_link[pzf_pkg::ORDER]);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload holds while the item waits
  always_ff @(posedge clk) begin
    if (accept) begin
      out_sample_r <= res.sample;
      out_sat_r    <= res.sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_saturated = out_sat_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pzf_coef_bank.sv =====
// Coefficient register bank of the IIR filter, written through the config port.
// Depends on pzf_pkg.
`default_nettype none

module pzf_coef_bank (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [pzf_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [pzf_pkg::COEF_W-1:0]     cfg_data,
  output pzf_pkg::coef_bank_t                 coef
);

  pzf_pkg::coef_bank_t coef_r, coef_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_wr_en) begin
      for (int k = 0; k <= pzf_pkg::ORDER; k++) begin
        if (cfg_index == pzf_pkg::REG_IDX_W'(pzf_pkg::REG_ZERO_0 + k)) begin
          coef_nxt.zero[k] = cfg_data;
        end
      end
      for (int k = 1; k <= pzf_pkg::ORDER; k++) begin
        if (cfg_index == pzf_pkg::REG_IDX_W'(pzf_pkg::REG_POLE_1 + k - 1)) begin
          coef_nxt.pole[k] = cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= pzf_pkg::COEF_RESET;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pzf_tap_cell.sv =====
// One tap of the direct form I chain: holds one input and one output history
// entry; running sum + zero product - pole product. Depends on pzf_pkg.
`default_nettype none

module pzf_tap_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               shift_en,
  input  wire pzf_pkg::sample_t   x_in,
  input  wire pzf_pkg::sample_t   y_in,
  input  wire pzf_pkg::coef_t     zero_coef,
  input  wire pzf_pkg::coef_t     pole_coef,
  input  wire pzf_pkg::acc_t      sum_in,
  output pzf_pkg::sample_t        x_out,
  output pzf_pkg::sample_t        y_out,
  output pzf_pkg::acc_t           sum_out
);

  pzf_pkg::sample_t x_r, y_r;
  pzf_pkg::prod_t   zero_prod, pole_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (shift_en) begin
      x_r <= x_in;
      y_r <= y_in;
    end
  end

  assign zero_prod = pzf_pkg::prod_t'(zero_coef) * pzf_pkg::prod_t'(x_r);
  assign pole_prod = pzf_pkg::prod_t'(pole_coef) * pzf_pkg::prod_t'(y_r);
  // feedback term is subtracted
  assign sum_out   = sum_in + pzf_pkg::acc_t'(zero_prod) - pzf_pkg::acc_t'(pole_prod);
  assign x_out     = x_r;
  assign y_out     = y_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pzf_checker.sv =====
// Port-level checks of the IIR filter, bound to the top level.
// Depends on pole_zero_iir_filter_top_assert.svh.
`default_nettype none

`include "pole_zero_iir_filter_top_assert.svh"

module pzf_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [15:0]                    out_sample,
  input wire logic                           out_saturated
);

  `PZF_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "output valid after reset")

  `PZF_ASSERT(a_empty_takes_item, !out_valid |-> in_ready, "input stalled with empty output")

  `PZF_ASSERT(a_item_gives_result, in_valid && in_ready |=> out_valid, "accepted item gave no result")

  `PZF_ASSERT(a_sat_at_limit, out_valid && out_saturated |-> out_sample == 16'h7fff || out_sample == 16'h8000, "saturated flag off the limits")

  `PZF_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_saturated), "result changed under stall")

endmodule

bind pole_zero_iir_filter_top pzf_checker u_pzf_checker (.*);

`default_nettype wire
